>>> hdl/imf_pkg.sv
package imf_pkg;

    localparam int MAX_WIDTH     = 128;
    localparam int MAX_HEIGHT    = 128;
    localparam int SAMPLE_BITS   = 16;
    localparam int COL_BITS      = $clog2(MAX_WIDTH);
    localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
    localparam int DIM_BITS      = 8;
    localparam int MIN_DIM       = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam int NUM_EMIT      = 4;

    localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(72);

    // result kinds an input word can trigger, in output order
    localparam int EMIT_INNER  = 0;
    localparam int EMIT_RIGHT  = 1;
    localparam int EMIT_BOTTOM = 2;
    localparam int EMIT_CORNER = 3;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [COL_BITS-1:0]           t_col;
    typedef logic [ROW_BITS-1:0]           t_row;
    typedef logic [DIM_BITS-1:0]           t_dim;
    typedef logic [NUM_EMIT-1:0]           t_emit;

    typedef struct packed {
        t_sample sample;
    } t_in_word;

    typedef struct packed {
        t_col    col;
        t_row    row;
        t_sample median_3x3;
        t_sample median_2x2;
        logic    frame_last;
    } t_out_word;

    typedef struct packed {
        t_sample older;
        t_sample prev;
    } t_line_word;

    typedef struct packed {
        logic       en;
        t_col       addr;
        t_line_word data;
    } t_mem_wr;

    typedef struct packed {
        t_col  col;
        t_row  rm1;
        t_emit emit;
        logic  top2;
        logic  left2;
    } t_item;

    typedef struct packed {
        t_sample [8:0] win9;
        t_sample [3:0] win4;
        t_col          col;
        t_row          row;
        logic          last;
    } t_desc;

endpackage

>>> hdl/imf_if.sv
interface imf_in_if;
    import imf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface imf_out_if;
    import imf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/image_median_filter_3x3_2x2.sv
// channel  dir  handshake               contents
// i_in     in   valid / ready           sample
// o_out    out  valid / ready           col, row, median_3x3, median_2x2, frame_last
// apb      in   psel, penable, pwrite   frame_width at 0x0, frame_height at 0x4
//
// one word per cycle while each word completes at most one result and o_out.ready
// is high; a word at a row end or on the last row can complete two results (four on
// the bottom-right pixel) and holds i_in until the single median pipeline fed from the
// window takes them all. results pass stage b, stage c and median stages s0 to s3.
// reset is synchronous: sizes back to 72, position and window cleared, line stores kept.
// o_out.ready low with a result waiting freezes the median pipeline and backs up to i_in.ready.
module image_median_filter_3x3_2x2 (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    imf_in_if.sink                               i_in,
    imf_out_if.source                            o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [imf_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [imf_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [imf_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);
    import imf_pkg::*;

    function automatic t_col f_width_m1(input t_dim v);
        if (v < t_dim'(MIN_DIM)) begin
            return t_col'(MIN_DIM - 1);
        end else if (v > t_dim'(MAX_WIDTH)) begin
            return t_col'(MAX_WIDTH - 1);
        end
        return t_col'(v - t_dim'(1));
    endfunction

    function automatic t_row f_height_m1(input t_dim v);
        if (v < t_dim'(MIN_DIM)) begin
            return t_row'(MIN_DIM - 1);
        end else if (v > t_dim'(MAX_HEIGHT)) begin
            return t_row'(MAX_HEIGHT - 1);
        end
        return t_row'(v - t_dim'(1));
    endfunction

    t_dim       r_frame_width;
    t_dim       r_frame_height;
    t_col       r_w_m1;
    t_row       r_h_m1;
    t_col       r_col;
    t_row       r_row;
    t_col       n_col;
    t_row       n_row;

    logic       cfg_wr;
    t_reg_idx   cfg_idx;
    logic       in_ready;
    logic       accept;
    t_item      item;
    t_mem_wr    mem_wr;
    t_line_word rd_data;
    logic       med_adv;
    logic       desc_valid;
    t_desc      desc;
    logic       col_end;
    logic       row_end;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(r_frame_height);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= DIM_RESET;
            r_frame_height <= DIM_RESET;
            r_w_m1         <= f_width_m1(DIM_RESET);
            r_h_m1         <= f_height_m1(DIM_RESET);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[DIM_BITS-1:0];
                    r_w_m1        <= f_width_m1(pwdata[DIM_BITS-1:0]);
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[DIM_BITS-1:0];
                    r_h_m1         <= f_height_m1(pwdata[DIM_BITS-1:0]);
                end
            endcase
        end
    end

    assign i_in.ready = in_ready;
    assign accept     = i_in.valid && in_ready;
    assign col_end    = (r_col == r_w_m1);
    assign row_end    = (r_row == r_h_m1);

    // raster position of the next word; a size write starts a new frame
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (cfg_wr) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + t_row'(1);
            end else begin
                n_col = r_col + t_col'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        item.col               = r_col;
        item.rm1               = r_row - t_row'(1);
        item.top2              = (r_row == t_row'(1));
        item.left2             = (r_col == t_col'(1));
        item.emit[EMIT_INNER]  = (r_row != '0) && (r_col != '0);
        item.emit[EMIT_RIGHT]  = (r_row != '0) && col_end;
        item.emit[EMIT_BOTTOM] = row_end && (r_col != '0);
        item.emit[EMIT_CORNER] = row_end && col_end;
    end

    imf_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .i_wr      (mem_wr),
        .o_rd_data (rd_data)
    );

    imf_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_sample     (i_in.payload.sample),
        .i_item       (item),
        .i_rd_data    (rd_data),
        .i_w_m1       (r_w_m1),
        .i_h_m1       (r_h_m1),
        .i_adv        (med_adv),
        .o_ready      (in_ready),
        .o_wr         (mem_wr),
        .o_desc_valid (desc_valid),
        .o_desc       (desc)
    );

    imf_median u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (desc_valid),
        .i_desc  (desc),
        .i_ready (o_out.ready),
        .o_adv   (med_adv),
        .o_valid (o_out.valid),
        .o_word  (o_out.payload)
    );

`ifndef ASSERT_OFF
    // write-back of one word never lands on the entry the next word reads
    a_line_store_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_wr.en && accept) |-> (mem_wr.addr != r_col))
        else $error("line store write and read hit the same entry");

    a_frame_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.frame_last) |->
        (o_out.payload.col == r_w_m1 && o_out.payload.row == r_h_m1))
        else $error("frame_last away from the bottom-right pixel");

    a_position_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && col_end && row_end) |=> (r_col == '0 && r_row == '0))
        else $error("position did not wrap after the last pixel");
`endif

endmodule

>>> hdl/imf_line_mem.sv
module imf_line_mem (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  imf_pkg::t_col       i_rd_addr,
    input  imf_pkg::t_mem_wr    i_wr,
    output imf_pkg::t_line_word o_rd_data
);
    import imf_pkg::*;

    // both line stores share one word: older row above, previous row below
    t_line_word r_mem [MAX_WIDTH];
    t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/imf_window.sv
module imf_window (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  imf_pkg::t_sample    i_sample,
    input  imf_pkg::t_item      i_item,
    input  imf_pkg::t_line_word i_rd_data,
    input  imf_pkg::t_col       i_w_m1,
    input  imf_pkg::t_row       i_h_m1,
    input  logic                i_adv,
    output logic                o_ready,
    output imf_pkg::t_mem_wr    o_wr,
    output logic                o_desc_valid,
    output imf_pkg::t_desc      o_desc
);
    import imf_pkg::*;

    // stage b: word waiting for its line store read
    logic    r_b_valid;
    t_sample r_b_sample;
    t_item   r_b_item;

    // stage c: window and the results still to be issued from it
    t_sample r_win [3][3];
    t_emit   r_emit;
    logic    r_top2;
    logic    r_left2;
    t_col    r_cm1;
    t_row    r_rm1;

    logic    n_b_valid;
    t_emit   n_emit;
    logic    c_busy;
    logic    c_free;
    logic    b_fire;
    logic    use_last;
    logic    use_end;
    t_sample sel_row [3][3];

    assign c_busy = (r_emit != '0);
    // free when idle, or once the last pending result leaves this cycle
    assign c_free = !c_busy || (i_adv && ((r_emit & (r_emit - t_emit'(1))) == '0));
    assign b_fire = r_b_valid && c_free;
    assign o_ready = !r_b_valid || c_free;

    always_comb begin
        n_b_valid = r_b_valid;
        if (i_accept) begin
            n_b_valid = 1'b1;
        end else if (b_fire) begin
            n_b_valid = 1'b0;
        end
    end

    always_comb begin
        n_emit = r_emit;
        if (b_fire) begin
            n_emit = r_b_item.emit;
        end else if (i_adv && c_busy) begin
            n_emit = r_emit & (r_emit - t_emit'(1));
        end
    end

    // lowest pending kind goes first
    always_comb begin
        priority if (r_emit[EMIT_INNER]) begin
            use_last = 1'b0;
            use_end  = 1'b0;
        end else if (r_emit[EMIT_RIGHT]) begin
            use_last = 1'b0;
            use_end  = 1'b1;
        end else if (r_emit[EMIT_BOTTOM]) begin
            use_last = 1'b1;
            use_end  = 1'b0;
        end else begin
            use_last = 1'b1;
            use_end  = 1'b1;
        end
    end

    // mirrored rows then mirrored columns, all from fixed taps
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sel_row[0][j] = use_last ? r_win[1][j] : (r_top2 ? r_win[2][j] : r_win[0][j]);
            sel_row[1][j] = use_last ? r_win[2][j] : r_win[1][j];
            sel_row[2][j] = use_last ? r_win[1][j] : r_win[2][j];
        end
        for (int i = 0; i < 3; i++) begin
            o_desc.win9[i*3]   = use_end ? sel_row[i][1]
                                         : (r_left2 ? sel_row[i][2] : sel_row[i][0]);
            o_desc.win9[i*3+1] = use_end ? sel_row[i][2] : sel_row[i][1];
            o_desc.win9[i*3+2] = use_end ? sel_row[i][1] : sel_row[i][2];
        end
        // the 2x2 block is the same four taps whichever way it is mirrored
        o_desc.win4[0] = r_win[1][1];
        o_desc.win4[1] = r_win[1][2];
        o_desc.win4[2] = r_win[2][1];
        o_desc.win4[3] = r_win[2][2];
        o_desc.col     = use_end ? i_w_m1 : r_cm1;
        o_desc.row     = use_last ? i_h_m1 : r_rm1;
        o_desc.last    = r_emit == t_emit'(1 << EMIT_CORNER);
    end

    assign o_desc_valid = c_busy;

    assign o_wr.en         = b_fire;
    assign o_wr.addr       = r_b_item.col;
    assign o_wr.data.older = i_rd_data.prev;
    assign o_wr.data.prev  = r_b_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_emit    <= '0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else begin
            r_b_valid <= n_b_valid;
            r_emit    <= n_emit;
            if (b_fire) begin
                for (int i = 0; i < 3; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= i_rd_data.older;
                r_win[1][2] <= i_rd_data.prev;
                r_win[2][2] <= r_b_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b_sample <= i_sample;
            r_b_item   <= i_item;
        end
        if (b_fire) begin
            r_top2  <= r_b_item.top2;
            r_left2 <= r_b_item.left2;
            r_cm1   <= r_b_item.col - t_col'(1);
            r_rm1   <= r_b_item.rm1;
        end
    end

endmodule

>>> hdl/imf_median.sv
module imf_median (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  imf_pkg::t_desc     i_desc,
    input  logic               i_ready,
    output logic               o_adv,
    output logic               o_valid,
    output imf_pkg::t_out_word o_word
);
    import imf_pkg::*;

    typedef struct packed {
        t_col col;
        t_row row;
        logic last;
    } t_meta;

    function automatic t_sample f_min(input t_sample x, input t_sample y);
        return (x < y) ? x : y;
    endfunction

    function automatic t_sample f_max(input t_sample x, input t_sample y);
        return (x < y) ? y : x;
    endfunction

    function automatic t_sample f_med3(input t_sample x, input t_sample y, input t_sample z);
        return f_max(f_min(x, y), f_min(f_max(x, y), z));
    endfunction

    logic      adv;
    logic      r_s0_valid;
    logic      r_s1_valid;
    logic      r_s2_valid;
    logic      r_s3_valid;
    t_desc     r_s0_desc;
    t_sample   r_s1_lo [3];
    t_sample   r_s1_mid [3];
    t_sample   r_s1_hi [3];
    t_sample   r_s1_plo [2];
    t_sample   r_s1_phi [2];
    t_meta     r_s1_meta;
    t_sample   r_s2_lo_max;
    t_sample   r_s2_mid_med;
    t_sample   r_s2_hi_min;
    t_sample   r_s2_m4;
    t_meta     r_s2_meta;
    t_out_word r_s3_word;

    // whole pipeline moves together, held while the output word waits
    assign adv = !r_s3_valid || i_ready;
    assign o_adv = adv;
    assign o_valid = r_s3_valid;
    assign o_word = r_s3_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= i_valid;
            r_s1_valid <= r_s0_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_desc <= i_desc;

            // sort each row of three, sort the two pairs
            for (int i = 0; i < 3; i++) begin
                r_s1_lo[i]  <= f_min(f_min(r_s0_desc.win9[i*3], r_s0_desc.win9[i*3+1]),
                                     r_s0_desc.win9[i*3+2]);
                r_s1_mid[i] <= f_med3(r_s0_desc.win9[i*3], r_s0_desc.win9[i*3+1],
                                      r_s0_desc.win9[i*3+2]);
                r_s1_hi[i]  <= f_max(f_max(r_s0_desc.win9[i*3], r_s0_desc.win9[i*3+1]),
                                     r_s0_desc.win9[i*3+2]);
            end
            for (int k = 0; k < 2; k++) begin
                r_s1_plo[k] <= f_min(r_s0_desc.win4[k*2], r_s0_desc.win4[k*2+1]);
                r_s1_phi[k] <= f_max(r_s0_desc.win4[k*2], r_s0_desc.win4[k*2+1]);
            end
            r_s1_meta <= '{col: r_s0_desc.col, row: r_s0_desc.row, last: r_s0_desc.last};

            r_s2_lo_max  <= f_max(f_max(r_s1_lo[0], r_s1_lo[1]), r_s1_lo[2]);
            r_s2_mid_med <= f_med3(r_s1_mid[0], r_s1_mid[1], r_s1_mid[2]);
            r_s2_hi_min  <= f_min(f_min(r_s1_hi[0], r_s1_hi[1]), r_s1_hi[2]);
            // third smallest of four is the second largest
            r_s2_m4      <= f_max(f_min(r_s1_phi[0], r_s1_phi[1]),
                                  f_max(r_s1_plo[0], r_s1_plo[1]));
            r_s2_meta    <= r_s1_meta;

            r_s3_word.col        <= r_s2_meta.col;
            r_s3_word.row        <= r_s2_meta.row;
            r_s3_word.median_3x3 <= f_med3(r_s2_lo_max, r_s2_mid_med, r_s2_hi_min);
            r_s3_word.median_2x2 <= r_s2_m4;
            r_s3_word.frame_last <= r_s2_meta.last;
        end
    end

endmodule
